FILE: rtl/core/lpmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_pkg
// Shared types and constants for the length-prefixed message filter.
// ----------------------------------------------------------------------------
package lpmf_pkg;

    localparam int BYTE_W        = 8;
    localparam int KEY_W         = 16;
    localparam int LEN_W         = 16;
    localparam int HDR_BYTES     = 4;
    localparam int HDR_AW        = 2;
    localparam int BEAT_IDX_W    = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;
    localparam int QUEUE_CNT_W   = 3;
    localparam int MIN_KEYED_LEN = 3;

    localparam logic [KEY_W-1:0] TARGET_KEY_RESET = 16'd13;

    typedef enum logic [2:0] {
        PH_LEN_HI = 3'd0,
        PH_LEN_LO = 3'd1,
        PH_TYPE   = 3'd2,
        PH_KEY_HI = 3'd3,
        PH_KEY_LO = 3'd4,
        PH_BODY   = 3'd5
    } phase_t;

    // One queued job for the output side: either the five-beat header burst
    // or a single body byte.
    typedef struct packed {
        logic                              burst;
        logic                              msg_end;
        logic [HDR_BYTES-1:0][BYTE_W-1:0]  hdr;
        logic [BYTE_W-1:0]                 tail;
    } lpmf_cmd_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } lpmf_q_status_t;

endpackage

FILE: rtl/core/lpmf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_in_if
// Input byte channel: valid/ready handshake with one stream byte per beat.
// ----------------------------------------------------------------------------
interface lpmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

FILE: rtl/core/lpmf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_out_if
// Output byte channel: forwarded message bytes with end markers.
// ----------------------------------------------------------------------------
interface lpmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       message_end;
    logic       run_last;

    modport source (output valid, output out_byte, output message_end,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input message_end,
                    input run_last, output ready);
endinterface

FILE: rtl/core/lpmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_front
// Message parser: tracks the header, matches the key, queues output jobs.
// ----------------------------------------------------------------------------
module lpmf_front
    import lpmf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [KEY_W-1:0]    cfg_wr_data,
    lpmf_in_if.sink             in_ch,
    input  lpmf_q_status_t      q_status,
    output logic                push,
    output lpmf_cmd_t           push_cmd
);

    phase_t                           phase_reg, phase_next;
    logic [LEN_W-1:0]                 left_reg, left_next;
    logic                             fwd_reg, fwd_next;
    logic [KEY_W-1:0]                 key_reg;
    logic [HDR_BYTES-1:0][BYTE_W-1:0] hold_reg, hold_next;

    logic                             accept;
    logic [BYTE_W-1:0]                b;
    logic [LEN_W-1:0]                 len;
    logic [LEN_W-1:0]                 left_dec;
    logic                             done;
    logic                             match;

    assign in_ch.ready = !q_status.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign b           = in_ch.data_byte;
    assign len         = {hold_reg[0], b};
    assign left_dec    = left_reg - LEN_W'(1);
    assign done        = (left_dec == '0);
    assign match       = ({hold_reg[3], b} == key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= TARGET_KEY_RESET;
        end
        else if (cfg_wr_en)
        begin
            key_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN_HI;
            left_reg  <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            fwd_reg   <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        left_next      = left_reg;
        fwd_next       = fwd_reg;
        hold_next      = hold_reg;
        push           = 1'b0;
        push_cmd.burst   = 1'b0;
        push_cmd.msg_end = done;
        push_cmd.hdr     = hold_reg;
        push_cmd.tail    = b;
        if (accept)
        begin
            unique case (phase_reg)
                PH_LEN_LO:
                begin
                    hold_next[1] = b;
                    left_next    = len;
                    fwd_next     = 1'b0;
                    if (len == '0)
                        phase_next = PH_LEN_HI;
                    else if (len < LEN_W'(MIN_KEYED_LEN))
                        phase_next = PH_BODY;
                    else
                        phase_next = PH_TYPE;
                end
                PH_TYPE:
                begin
                    hold_next[2] = b;
                    left_next    = left_dec;
                    phase_next   = PH_KEY_HI;
                end
                PH_KEY_HI:
                begin
                    hold_next[3] = b;
                    left_next    = left_dec;
                    phase_next   = PH_KEY_LO;
                end
                PH_KEY_LO:
                begin
                    left_next      = left_dec;
                    push           = match;
                    push_cmd.burst = 1'b1;
                    fwd_next       = match && !done;
                    phase_next     = done ? PH_LEN_HI : PH_BODY;
                end
                PH_BODY:
                begin
                    left_next = left_dec;
                    push      = fwd_reg;
                    if (done)
                    begin
                        fwd_next   = 1'b0;
                        phase_next = PH_LEN_HI;
                    end
                end
                default:
                begin
                    hold_next[0] = b;
                    phase_next   = PH_LEN_LO;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/lpmf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_queue
// Short job queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module lpmf_queue
    import lpmf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lpmf_cmd_t       push_cmd,
    input  logic            pop,
    output lpmf_cmd_t       head_cmd,
    output lpmf_q_status_t  status
);

    lpmf_cmd_t               mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg;
    logic [QUEUE_AW-1:0]     rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]  cnt_reg;

    assign status.not_empty = (cnt_reg != '0);
    assign status.full      = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_cmd         = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QUEUE_CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QUEUE_CNT_W'(1);
        end
    end

endmodule

FILE: rtl/core/lpmf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpmf_back
// Output sequencer: expands queued jobs into beats behind an output register.
// ----------------------------------------------------------------------------
module lpmf_back
    import lpmf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  lpmf_cmd_t       head_cmd,
    input  lpmf_q_status_t  q_status,
    output logic            pop,
    lpmf_out_if.source      out_ch
);

    logic [BEAT_IDX_W-1:0] idx_reg;
    logic                  valid_reg;
    logic [BYTE_W-1:0]     byte_reg;
    logic                  end_reg;
    logic                  last_reg;

    logic                  load;
    logic                  final_beat;
    logic [BYTE_W-1:0]     beat_byte;

    assign load       = q_status.not_empty && (!valid_reg || out_ch.ready);
    assign final_beat = !head_cmd.burst || (idx_reg == BEAT_IDX_W'(HDR_BYTES));
    assign beat_byte  = final_beat ? head_cmd.tail
                                   : head_cmd.hdr[idx_reg[HDR_AW-1:0]];
    assign pop        = load && final_beat;

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.message_end = end_reg;
    assign out_ch.run_last    = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
                valid_reg <= 1'b1;
            else if (out_ch.ready)
                valid_reg <= 1'b0;
            if (load)
                idx_reg <= final_beat ? '0 : idx_reg + BEAT_IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= beat_byte;
            end_reg  <= final_beat && head_cmd.msg_end;
            last_reg <= final_beat;
        end
    end

endmodule

FILE: rtl/core/length_prefixed_message_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_message_filter
// Forwards length-prefixed messages whose 16-bit key matches a target key.
// ----------------------------------------------------------------------------
// The block takes one stream byte per beat and accepts a byte in every cycle
// while its four-entry job queue has room. Each message is a big-endian
// 16-bit body length followed by the body; body byte 0 is a type and body
// bytes 1-2 a big-endian key. The length, type and key-high bytes are held
// until the key-low byte arrives; if the key equals target_key the whole
// message leaves, length bytes included, otherwise it is dropped. Messages
// with fewer than three body bytes (and empty ones) are always dropped. The
// key-low byte releases a burst of five beats (run_last on the fifth); every
// later body byte yields one beat. message_end marks the final byte of a
// forwarded message. Output beats leave at one per cycle while the sink is
// ready, from a registered output stage behind the job queue; the burst
// takes one queue entry, but only three later body jobs fit behind it, so
// the input can stall after a burst even while the sink takes every beat.
// Write target_key (reset value 13) only while the block is idle.
// ----------------------------------------------------------------------------
module length_prefixed_message_filter
    import lpmf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [KEY_W-1:0]   cfg_wr_data,
    lpmf_in_if.sink            in_ch,
    lpmf_out_if.source         out_ch
);

    logic            push;
    lpmf_cmd_t       push_cmd;
    logic            pop;
    lpmf_cmd_t       head_cmd;
    lpmf_q_status_t  q_status;

    // Parse headers and queue a job per byte that produces output.
    lpmf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .q_status    (q_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Hold jobs so that the parser and the sink stall independently.
    lpmf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Expand each job into output beats.
    lpmf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule
